// ===== design/pdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_pkg
// Shared types and constants of the positional PID DAC loop.
// ----------------------------------------------------------------------------
package pdl_pkg;

   localparam int CODE_W     = 8;
   localparam int CLAMP_W    = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int GAIN_W     = 24;
   localparam int SCALE_W    = 20;
   localparam int WORD_W     = 32;
   localparam int MUL_A_W    = 34;
   localparam int MUL_B_W    = 25;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PID_ENABLE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KP_GAIN    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KI_GAIN    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KD_GAIN    = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REF_SCALE  = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FB_SCALE   = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_OFFSET = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_OFFSET = 8'd7;

   // register reset values
   localparam logic [GAIN_W-1:0]  KP_RESET   = 24'd65536;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd65536;
   localparam logic [WORD_W-1:0]  OUT_OFFSET_RESET = 32'd8388608;

   // clamp status codes
   localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
   localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
   localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

   localparam logic [CODE_W-1:0] CODE_MAX = 8'd255;
   localparam logic [CODE_W-1:0] CODE_MIN = 8'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_REF,
      ST_MUL_FB,
      ST_ERR,
      ST_SAT_E,
      ST_MUL_KI,
      ST_MUL_KP,
      ST_MUL_KD,
      ST_ADD_D,
      ST_ADD_OFS,
      ST_CLAMP
   } pdl_state_type;

   typedef struct packed {
      logic                      en;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } pdl_mul_req_type;

   // saturate a wide signed value to signed 32 bits
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] max_v;
      logic signed [ACC_W-1:0] min_v;
      logic signed [WORD_W-1:0] r;
      max_v = ACC_W'(64'sh7FFF_FFFF);
      min_v = -ACC_W'(64'sh8000_0000);
      if (x > max_v) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < min_v) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/pdl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_if
// Valid/ready channels of the PID DAC loop: sample, result and CSR write.
// ----------------------------------------------------------------------------
interface pdl_req_if import pdl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] setpoint_code;
   logic [CODE_W-1:0] feedback_code;
   modport source (output valid, output setpoint_code, output feedback_code, input ready);
   modport sink   (input valid, input setpoint_code, input feedback_code, output ready);
endinterface

interface pdl_rsp_if import pdl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  dac_code;
   logic [CLAMP_W-1:0] clamp_state;
   modport source (output valid, output dac_code, output clamp_state, input ready);
   modport sink   (input valid, input dac_code, input clamp_state, output ready);
endinterface

interface pdl_csr_if import pdl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pdl_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module pdl_mul import pdl_pkg::*; (
   input  logic                     clock,
   input  pdl_mul_req_type          mul_req,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== design/positional_pid_dac_loop_unit.sv =====
`timescale 1ns / 1ps
// Sequencer steps through one shared multiplier from sample transaction to
//   result valid; with PID disabled the gain steps are skipped.
// One sample in flight at a time: req ready only while idle; a held result
//   stalls the sequencer's last step.
// Reset (synchronous, active high): registers to defaults, last error and
//   integral cleared, no result pending.
// ----------------------------------------------------------------------------
// positional_pid_dac_loop_unit
// Positional PID from two 8-bit ADC codes to an 8-bit DAC code, computed by
// a small sequencer around one multiplier and one accumulator adder.
// ----------------------------------------------------------------------------
module positional_pid_dac_loop_unit import pdl_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   pdl_req_if.sink   req_if,
   pdl_rsp_if.source rsp_if,
   pdl_csr_if.sink   csr_if
);

   // rounding / clamp limits in Q format
   localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] HI_Q   = (ACC_W'(254) << FRAC_BITS) + HALF_Q;

   // ---------------- configuration registers ----------------
   logic                      pid_enable_ff;
   logic [GAIN_W-1:0]         kp_gain_ff, ki_gain_ff, kd_gain_ff;
   logic signed [SCALE_W-1:0] ref_scale_ff, fb_scale_ff;
   logic signed [WORD_W-1:0]  err_offset_ff, out_offset_ff;

   logic csr_write;
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_enable_ff <= 1'b0;
         kp_gain_ff    <= KP_RESET;
         ki_gain_ff    <= '0;
         kd_gain_ff    <= '0;
         ref_scale_ff  <= SCALE_RESET;
         fb_scale_ff   <= SCALE_RESET;
         err_offset_ff <= '0;
         out_offset_ff <= OUT_OFFSET_RESET;
      end else if (csr_write) begin
         case (csr_if.index)
            REG_PID_ENABLE: pid_enable_ff <= csr_if.data[0];
            REG_KP_GAIN:    kp_gain_ff    <= csr_if.data[GAIN_W-1:0];
            REG_KI_GAIN:    ki_gain_ff    <= csr_if.data[GAIN_W-1:0];
            REG_KD_GAIN:    kd_gain_ff    <= csr_if.data[GAIN_W-1:0];
            REG_REF_SCALE:  ref_scale_ff  <= csr_if.data[SCALE_W-1:0];
            REG_FB_SCALE:   fb_scale_ff   <= csr_if.data[SCALE_W-1:0];
            REG_ERR_OFFSET: err_offset_ff <= csr_if.data[WORD_W-1:0];
            REG_OUT_OFFSET: out_offset_ff <= csr_if.data[WORD_W-1:0];
            default: ; // unmapped index: dropped
         endcase
      end
   end

   // ---------------- sequencer and datapath state ----------------
   pdl_state_type state_ff, state_in;

   logic [CODE_W-1:0]        sp_ff, fb_ff;          // captured sample
   logic signed [WORD_W-1:0] e_ff;                  // saturated error
   logic signed [WORD_W:0]   diff_ff;               // e - previous e
   logic signed [WORD_W-1:0] last_ff, last_in;      // previous error
   logic signed [WORD_W-1:0] integ_ff, integ_in;    // integral term
   logic signed [ACC_W-1:0]  acc_ff, acc_in;        // accumulator
   logic                     e_load, integ_load, acc_load;
   logic signed [WORD_W:0]   diff_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]        dac_code_ff, dac_code_in;
   logic [CLAMP_W-1:0]       clamp_ff, clamp_in;

   logic req_accept;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // shared multiplier
   pdl_mul_req_type          mul_req;
   logic signed [PROD_W-1:0] prod_ff;

   pdl_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   // shared adder operands; prod_q is the floored Q product
   logic signed [ACC_W-1:0] add_a, add_b, add_sum;
   logic signed [ACC_W-1:0] prod_sx, prod_q;
   logic signed [WORD_W-1:0] acc_sat;
   logic signed [ACC_W-1:0] round_v;

   assign prod_sx = ACC_W'(prod_ff);
   assign prod_q  = prod_sx >>> FRAC_BITS;
   assign add_sum = add_a + add_b;
   assign acc_sat = sat32(acc_ff);
   assign round_v = acc_ff + HALF_Q;
   assign diff_in = (WORD_W+1)'(acc_sat) - (WORD_W+1)'(last_ff);

   always_comb begin
      state_in     = state_ff;
      mul_req      = '0;
      add_a        = '0;
      add_b        = '0;
      acc_load     = 1'b0;
      e_load       = 1'b0;
      integ_load   = 1'b0;
      integ_in     = integ_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      dac_code_in  = dac_code_ff;
      clamp_in     = clamp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MUL_REF;
            end
         end
         ST_MUL_REF: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(sp_ff);
            mul_req.b  = MUL_B_W'(ref_scale_ff);
            state_in   = ST_MUL_FB;
         end
         ST_MUL_FB: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(fb_ff);
            mul_req.b  = MUL_B_W'(fb_scale_ff);
            add_a      = ACC_W'(err_offset_ff);
            add_b      = prod_sx;
            acc_load   = 1'b1;
            state_in   = ST_ERR;
         end
         ST_ERR: begin
            add_a    = acc_ff;
            add_b    = -prod_sx;
            acc_load = 1'b1;
            state_in = ST_SAT_E;
         end
         ST_SAT_E: begin
            // error saturates here; last error moves on every sample
            add_a    = ACC_W'(acc_sat);
            acc_load = 1'b1;
            e_load   = 1'b1;
            last_in  = acc_sat;
            state_in = pid_enable_ff ? ST_MUL_KI : ST_ADD_OFS;
         end
         ST_MUL_KI: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(e_ff);
            mul_req.b  = MUL_B_W'({1'b0, ki_gain_ff});
            state_in   = ST_MUL_KP;
         end
         ST_MUL_KP: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(e_ff);
            mul_req.b  = MUL_B_W'({1'b0, kp_gain_ff});
            add_a      = ACC_W'(integ_ff);
            add_b      = prod_q;
            acc_load   = 1'b1;
            state_in   = ST_MUL_KD;
         end
         ST_MUL_KD: begin
            // integral saturates, then the P term joins it
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(diff_ff);
            mul_req.b  = MUL_B_W'({1'b0, kd_gain_ff});
            integ_load = 1'b1;
            integ_in   = acc_sat;
            add_a      = ACC_W'(acc_sat);
            add_b      = prod_q;
            acc_load   = 1'b1;
            state_in   = ST_ADD_D;
         end
         ST_ADD_D: begin
            add_a    = acc_ff;
            add_b    = prod_q;
            acc_load = 1'b1;
            state_in = ST_ADD_OFS;
         end
         ST_ADD_OFS: begin
            add_a    = acc_ff;
            add_b    = ACC_W'(out_offset_ff);
            acc_load = 1'b1;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               if (acc_ff > HI_Q) begin
                  dac_code_in = CODE_MAX;
                  clamp_in    = CLAMP_HIGH;
               end else if (acc_ff < HALF_Q) begin
                  dac_code_in = CODE_MIN;
                  clamp_in    = CLAMP_LOW;
               end else begin
                  dac_code_in = round_v[FRAC_BITS +: CODE_W];
                  clamp_in    = CLAMP_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign acc_in = add_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         if (integ_load) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sp_ff <= req_if.setpoint_code;
         fb_ff <= req_if.feedback_code;
      end
      if (acc_load) begin
         acc_ff <= acc_in;
      end
      if (e_load) begin
         e_ff    <= acc_sat;
         diff_ff <= diff_in;
      end
      dac_code_ff <= dac_code_in;
      clamp_ff    <= clamp_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.dac_code    = dac_code_ff;
   assign rsp_if.clamp_state = clamp_ff;

   // ---------------- checks ----------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_MUL_REF)
      else $error("sample transaction did not start the sequencer");

   a_clamp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (clamp_ff == CLAMP_NONE || clamp_ff == CLAMP_HIGH ||
                        clamp_ff == CLAMP_LOW))
      else $error("bad clamp status");

   a_clamp_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && clamp_ff == CLAMP_HIGH) |-> dac_code_ff == CODE_MAX)
      else $error("high clamp without full-scale code");

   a_clamp_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && clamp_ff == CLAMP_LOW) |-> dac_code_ff == CODE_MIN)
      else $error("low clamp without zero code");

   a_integ_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_MUL_KD |=> $stable(integ_ff))
      else $error("integral moved outside its update step");

endmodule

// ===== bench/pdl_loop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_loop_checker
// Watches the sample, result and CSR channels of the PID DAC loop, keeps its
// own copy of the loop state, predicts each DAC code and compares in order.
// ----------------------------------------------------------------------------
module pdl_loop_checker import pdl_pkg::*; (
   input  logic clock,
   input  logic reset,
   pdl_req_if   req_if,
   pdl_rsp_if   rsp_if,
   pdl_csr_if   csr_if,
   output int   mismatch_count,
   output int   pending_count,
   output int   checked_count
);

   localparam int    FRAC     = 16;
   localparam longint HALF_LSB = longint'(1) <<< (FRAC - 1);
   localparam longint OUT_HI   = (longint'(254) <<< FRAC) + HALF_LSB;
   localparam int    PRINT_CAP = 40;

   typedef struct packed {
      logic [CODE_W-1:0]  dac_code;
      logic [CLAMP_W-1:0] clamp_state;
   } dac_result_type;

   dac_result_type expected_dac_q[$];

   // shadow registers
   logic                      pid_on;
   logic [GAIN_W-1:0]         kp_gain;
   logic [GAIN_W-1:0]         ki_gain;
   logic [GAIN_W-1:0]         kd_gain;
   logic signed [SCALE_W-1:0] ref_slope;
   logic signed [SCALE_W-1:0] fb_slope;
   logic signed [WORD_W-1:0]  err_bias;
   logic signed [WORD_W-1:0]  out_bias;

   // loop state
   longint prev_err;
   longint integ_sum;

   function automatic longint limit_word(input longint x);
      if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (x < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
      return x;
   endfunction

   // one sample through the loop; updates integral (PID only) and last error
   function automatic dac_result_type step_loop(input logic [CODE_W-1:0] sp_code,
                                                input logic [CODE_W-1:0] fb_code);
      dac_result_type r;
      longint      err;
      longint      ctl;
      longint      prop;
      longint      deriv;
      err = longint'(ref_slope) * longint'(sp_code)
          - longint'(fb_slope) * longint'(fb_code) + longint'(err_bias);
      err = limit_word(err);
      if (pid_on) begin
         prop      = (longint'(kp_gain) * err) >>> FRAC;
         deriv     = (longint'(kd_gain) * (err - prev_err)) >>> FRAC;
         integ_sum = limit_word(integ_sum + ((longint'(ki_gain) * err) >>> FRAC));
         ctl       = prop + integ_sum + deriv;
      end else begin
         ctl = err;
      end
      prev_err = err;
      ctl = ctl + longint'(out_bias);
      if (ctl > OUT_HI) begin
         r.dac_code    = CODE_MAX;
         r.clamp_state = CLAMP_HIGH;
      end else if (ctl < HALF_LSB) begin
         r.dac_code    = CODE_MIN;
         r.clamp_state = CLAMP_LOW;
      end else begin
         r.dac_code    = CODE_W'((ctl + HALF_LSB) >>> FRAC);
         r.clamp_state = CLAMP_NONE;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("pdl_loop_checker: %0t %s", $time, msg);
   endtask

   always @(posedge clock) begin
      dac_result_type want;
      if (reset) begin
         pid_on    = 1'b0;
         kp_gain   = KP_RESET;
         ki_gain   = '0;
         kd_gain   = '0;
         ref_slope = SCALE_RESET;
         fb_slope  = SCALE_RESET;
         err_bias  = '0;
         out_bias  = OUT_OFFSET_RESET;
         prev_err  = 0;
         integ_sum = 0;
         expected_dac_q.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_dac_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: code %0d clamp %0d",
                                         rsp_if.dac_code, rsp_if.clamp_state));
            end else begin
               want = expected_dac_q.pop_front();
               if (rsp_if.dac_code !== want.dac_code)
                  report_mismatch($sformatf("result %0d dac_code got %0d want %0d",
                                            checked_count, rsp_if.dac_code, want.dac_code));
               if (rsp_if.clamp_state !== want.clamp_state)
                  report_mismatch($sformatf("result %0d clamp_state got %0d want %0d",
                                            checked_count, rsp_if.clamp_state,
                                            want.clamp_state));
               checked_count++;
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               REG_PID_ENABLE: pid_on    = csr_if.data[0];
               REG_KP_GAIN:    kp_gain   = csr_if.data[GAIN_W-1:0];
               REG_KI_GAIN:    ki_gain   = csr_if.data[GAIN_W-1:0];
               REG_KD_GAIN:    kd_gain   = csr_if.data[GAIN_W-1:0];
               REG_REF_SCALE:  ref_slope = csr_if.data[SCALE_W-1:0];
               REG_FB_SCALE:   fb_slope  = csr_if.data[SCALE_W-1:0];
               REG_ERR_OFFSET: err_bias  = csr_if.data;
               REG_OUT_OFFSET: out_bias  = csr_if.data;
               default: ;  // writes past the register list are dropped
            endcase
         end
         if (req_if.valid && req_if.ready)
            expected_dac_q.push_back(step_loop(req_if.setpoint_code, req_if.feedback_code));
      end
      pending_count = expected_dac_q.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and CSR writes into the positional PID DAC loop, throttles
// the result side, and gives the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module tb_top;
   import pdl_pkg::*;

   // run shape
   localparam int SEGMENTS     = 14;
   localparam int PER_SEG      = 115;
   localparam int HOLD_LEN     = 300;   // long result-side stall, in cycles
   localparam int MAX_GAP      = 40;
   localparam int DRAIN_CYCLES = 40;    // idle time after the final drain, in cycles
   localparam int CYCLE_LIMIT  = 500000;

   // interesting register values
   localparam logic [GAIN_W-1:0]     GAIN_MAX  = 24'hFF_FFFF;
   localparam logic [SCALE_W-1:0]    SCALE_MAX = 20'h7_FFFF;
   localparam logic [SCALE_W-1:0]    SCALE_MIN = 20'h8_0000;
   localparam logic [CSR_DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [CSR_DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [CSR_DATA_W-1:0] MINUS_LSB = 32'hFFFF_FFFF;
   localparam logic [CSR_DATA_W-1:0] HALF_CNT  = 32'h0000_8000;        // 0.5 count
   localparam logic [CSR_DATA_W-1:0] TOP_EDGE  = (32'd254 << 16) + HALF_CNT;

   // indexes past the end of the register file
   localparam logic [CSR_IDX_W-1:0] REG_PAST_END  = 8'd8;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_SLOT = 8'hFF;

   logic clock = 1'b0;
   logic reset;

   pdl_req_if req_if ();
   pdl_rsp_if rsp_if ();
   pdl_csr_if csr_if ();

   int mismatch_count;
   int pending_count;
   int checked_count;

   int cycle_count   = 0;
   int samples_sent  = 0;
   int csr_writes    = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 86;
   bit burst_mode    = 1'b0;

   // long-stall requests: main flow bumps hold_asks, receiver serves them
   int hold_asks   = 0;
   int hold_served = 0;
   int hold_left   = 0;

   positional_pid_dac_loop_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   pdl_loop_checker checker_u (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_if         (csr_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: errors");
         $finish;
      end
   end

   // result side: random back-pressure, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left   = HOLD_LEN;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // one sample transaction; leaves valid high so back-to-back items need no gap
   task automatic send_sample(input logic [CODE_W-1:0] sp_code,
                              input logic [CODE_W-1:0] fb_code);
      int gap;
      gap = 0;
      if (!burst_mode)
         while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.setpoint_code <= sp_code;
      req_if.feedback_code <= fb_code;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      samples_sent++;
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic wait_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_writes++;
   endtask

   task automatic csr_rest();
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return GAIN_MAX;
         2, 3, 4: return GAIN_W'($urandom_range(0, 32'h1_0000));   // up to 1.0
         5, 6, 7: return GAIN_W'($urandom_range(0, 32'h2000));     // gentle
         default: return GAIN_W'($urandom());
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] rand_slope();
      case ($urandom_range(0, 9))
         0:       return SCALE_MIN;
         1:       return SCALE_MAX;
         7:       return SCALE_W'(32'hFFFF_0000 + $urandom_range(0, 32'h4000));
         8, 9:    return SCALE_W'($urandom());
         default: return SCALE_W'(32'h1_0000 + $urandom_range(0, 32'h4000) - 32'h2000);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_err_bias();
      case ($urandom_range(0, 9))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         8, 9:    return $urandom();
         default: return $urandom_range(0, 32'h28_0000) - 32'h14_0000;  // +-20 counts
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_out_bias();
      case ($urandom_range(0, 9))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         9:       return $urandom();
         default: return OUT_OFFSET_RESET + $urandom_range(0, 32'h80_0000) - 32'h40_0000;
      endcase
   endfunction

   // every register gets a fresh value; upper data bits carry junk to
   // exercise the field masking of the narrow registers
   task automatic set_random_config();
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom();
      csr_write(REG_PID_ENABLE, {junk[31:1], 1'($urandom_range(0, 9) < 7)});
      junk = $urandom();
      csr_write(REG_KP_GAIN, {junk[31:24], rand_gain()});
      junk = $urandom();
      csr_write(REG_KI_GAIN, {junk[31:24], rand_gain()});
      junk = $urandom();
      csr_write(REG_KD_GAIN, {junk[31:24], rand_gain()});
      junk = $urandom();
      csr_write(REG_REF_SCALE, {junk[31:20], rand_slope()});
      junk = $urandom();
      csr_write(REG_FB_SCALE, {junk[31:20], rand_slope()});
      csr_write(REG_ERR_OFFSET, rand_err_bias());
      csr_write(REG_OUT_OFFSET, rand_out_bias());
      if ($urandom_range(0, 4) == 0)
         csr_write(CSR_IDX_W'($urandom_range(REG_PAST_END, REG_LAST_SLOT)), $urandom());
      csr_rest();
   endtask

   // feedback settling toward the setpoint, with noise and setpoint steps
   task automatic track_run(input int n);
      int sp_code;
      int fb_code;
      int move;
      sp_code = $urandom_range(0, 255);
      fb_code = $urandom_range(0, 255);
      repeat (n) begin
         send_sample(CODE_W'(sp_code), CODE_W'(fb_code));
         move = (sp_code - fb_code) / int'($urandom_range(2, 6))
              + int'($urandom_range(0, 4)) - 2;
         fb_code += move;
         if (fb_code < 0) fb_code = 0;
         if (fb_code > 255) fb_code = 255;
         if ($urandom_range(0, 9) == 0) sp_code = $urandom_range(0, 255);
      end
   endtask

   task automatic noise_burst(input int n);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0:       send_sample(CODE_W'($urandom_range(0, 1) * 255),
                                 CODE_W'($urandom_range(0, 1) * 255));
            default: send_sample(CODE_W'($urandom()), CODE_W'($urandom()));
         endcase
      end
   endtask

   initial begin
      int seg_goal;
      int half_goal;
      bit paused;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.setpoint_code <= '0;
      req_if.feedback_code <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= '0;
      csr_if.data          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed: pass-through at reset defaults, code extremes
      send_sample(8'd0, 8'd0);
      send_sample(8'd255, 8'd0);
      send_sample(8'd0, 8'd255);
      send_sample(8'd255, 8'd255);
      send_sample(8'd128, 8'd127);
      wait_drain();

      // upper clamp edge: exactly 254.5 stays in range, one LSB more clamps
      csr_write(REG_OUT_OFFSET, TOP_EDGE);
      csr_rest();
      send_sample(8'd0, 8'd0);
      wait_drain();
      csr_write(REG_ERR_OFFSET, 32'd1);
      csr_rest();
      send_sample(8'd0, 8'd0);
      wait_drain();

      // lower clamp edge: exactly 0.5 rounds up to 1, one LSB less clamps
      csr_write(REG_OUT_OFFSET, HALF_CNT);
      csr_write(REG_ERR_OFFSET, '0);
      csr_rest();
      send_sample(8'd0, 8'd0);
      wait_drain();
      csr_write(REG_ERR_OFFSET, MINUS_LSB);
      csr_rest();
      send_sample(8'd0, 8'd0);
      wait_drain();

      // error saturation both ways with extreme slopes and offset
      csr_write(REG_OUT_OFFSET, OUT_OFFSET_RESET);
      csr_write(REG_REF_SCALE, SCALE_MAX);
      csr_write(REG_FB_SCALE, SCALE_MIN);
      csr_write(REG_ERR_OFFSET, WORD_MAX);
      csr_rest();
      send_sample(8'd255, 8'd255);
      wait_drain();
      csr_write(REG_REF_SCALE, SCALE_MIN);
      csr_write(REG_FB_SCALE, SCALE_MAX);
      csr_write(REG_ERR_OFFSET, WORD_MIN);
      csr_rest();
      send_sample(8'd255, 8'd255);
      wait_drain();

      // PID: integral runs into both saturation limits
      csr_write(REG_PID_ENABLE, 32'd1);
      csr_write(REG_KP_GAIN, '0);
      csr_write(REG_KI_GAIN, GAIN_MAX);
      csr_write(REG_KD_GAIN, '0);
      csr_write(REG_REF_SCALE, SCALE_RESET);
      csr_write(REG_FB_SCALE, SCALE_RESET);
      csr_write(REG_ERR_OFFSET, WORD_MAX);
      csr_rest();
      send_sample(8'd0, 8'd0);
      send_sample(8'd0, 8'd0);
      wait_drain();
      csr_write(REG_ERR_OFFSET, WORD_MIN);
      csr_rest();
      send_sample(8'd0, 8'd0);
      send_sample(8'd0, 8'd0);
      wait_drain();

      // PID: full proportional and derivative gain on error swings
      csr_write(REG_KI_GAIN, '0);
      csr_write(REG_KP_GAIN, GAIN_MAX);
      csr_write(REG_KD_GAIN, GAIN_MAX);
      csr_write(REG_ERR_OFFSET, '0);
      csr_rest();
      send_sample(8'd255, 8'd0);
      send_sample(8'd0, 8'd255);
      send_sample(8'd128, 8'd128);
      wait_drain();

      // writes past the register list must change nothing
      csr_write(REG_PAST_END, $urandom());
      csr_write(REG_LAST_SLOT, $urandom());
      csr_rest();
      send_sample(8'd10, 8'd20);

      // --- random segments, one register set each
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 5) begin
            send_idle_pct = 86;
            recv_idle_pct = 26;
         end else if (seg == 10) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_drain();
         set_random_config();
         // result side stalls long while samples keep coming back to back
         if (seg == 2 || seg == 11) begin
            hold_asks++;
            burst_mode = 1'b1;
            track_run(24);
            burst_mode = 1'b0;
         end
         seg_goal  = samples_sent + PER_SEG;
         half_goal = samples_sent + PER_SEG / 2;
         paused    = 1'b0;
         while (samples_sent < seg_goal) begin
            if (!paused && samples_sent >= half_goal) begin
               wait_drain();   // mid-segment pause, loop state carries over
               paused = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) track_run($urandom_range(5, 20));
            else noise_burst($urandom_range(1, 5));
         end
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d samples, %0d register writes, %0d results compared",
               samples_sent, csr_writes, checked_count);
      $display("tb_top: pass-through and PID settings, clamp edges, saturation, %0d long stalls",
               hold_asks);
      if (pending_count != 0) $display("tb_top: %0d results never came", pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
